[rtl/core/plt_pkg.sv]
// Shared operation codes, status codes and cell control type for the positional list table.
package plt_pkg;

	localparam logic [2:0] OP_INSERT   = 3'd0;
	localparam logic [2:0] OP_REPLACE  = 3'd1;
	localparam logic [2:0] OP_RETRIEVE = 3'd2;
	localparam logic [2:0] OP_REMOVE   = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	typedef struct packed {
		logic load_new;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

endpackage

[rtl/core/plt_cell.sv]
// One list cell: holds an entry, loads new data or a neighbor's entry.
module plt_cell #(
	parameter int ENTRY_BITS = 32
) (
	input  logic                    clk,
	input  plt_pkg::cell_ctl_t      ctl,
	input  logic [ENTRY_BITS-1:0]   left_d,
	input  logic [ENTRY_BITS-1:0]   right_d,
	input  logic [ENTRY_BITS-1:0]   new_d,
	output logic [ENTRY_BITS-1:0]   entry_q
);
	import plt_pkg::*;

	always_ff @(posedge clk) begin
		priority if (ctl.load_new) begin
			entry_q <= new_d;
		end else if (ctl.take_left) begin
			entry_q <= left_d;
		end else if (ctl.take_right) begin
			entry_q <= right_d;
		end else begin
			entry_q <= entry_q;
		end
	end

endmodule

[rtl/core/positional_list_table_unit.sv]
// Top level of the positional list table: cell chain, request decode and result register.
// The result is registered: it is valid in the output register in the cycle after the input transfer.
// Throughput: one request per cycle while the output is accepted; every cell shifts or loads in the same edge.
// The position read is an AND-OR over the cells addressed by the 5-bit position.
// Reset clears the fill count (not the entry_count output) and the output valid; cell contents are not reset.
module positional_list_table_unit #(
	parameter int CAPACITY   = 16,
	parameter int ENTRY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [4:0]  position,
	input  logic [31:0] value_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] value_out,
	output logic [4:0]  entry_count,
	output logic        is_empty,
	output logic        is_full
);
	import plt_pkg::*;

	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = (FW > 5) ? FW : 5;
	localparam int IB = (ENTRY_BITS < 32) ? ENTRY_BITS : 32;
	localparam int OB = (ENTRY_BITS < 32) ? ENTRY_BITS : 32;

	logic [FW-1:0]         fill_q;
	logic [ENTRY_BITS-1:0] cell_q [CAPACITY];
	cell_ctl_t             ctl    [CAPACITY];
	logic [ENTRY_BITS-1:0] new_val;
	logic [ENTRY_BITS-1:0] rd_val;
	logic [CW-1:0]         pos_x;
	logic [CW-1:0]         fill_x;
	logic                  in_fire;
	logic                  full_now;
	logic                  in_range;
	logic                  ins_ok;
	logic                  rep_ok;
	logic                  rem_ok;
	logic [1:0]            st_d;
	logic                  rd_use;
	logic [FW-1:0]         fill_d;

	assign in_fire  = in_valid && in_ready;
	assign in_ready = !out_valid || out_ready;
	assign new_val  = ENTRY_BITS'(value_in[IB-1:0]);
	assign pos_x    = CW'(position);
	assign fill_x   = CW'(fill_q);
	assign full_now = (fill_q == FW'(CAPACITY));
	assign in_range = (pos_x < fill_x);
	assign ins_ok   = (op == OP_INSERT) && !full_now && (pos_x <= fill_x);
	assign rep_ok   = (op == OP_REPLACE) && in_range;
	assign rem_ok   = (op == OP_REMOVE) && in_range;

	always_comb begin
		st_d   = ST_OK;
		rd_use = 1'b0;
		fill_d = fill_q;
		unique case (op)
			OP_INSERT: begin
				if (full_now) begin
					st_d = ST_OVERFLOW;
				end else if (!ins_ok) begin
					st_d = ST_RANGE;
				end else begin
					fill_d = fill_q + FW'(1);
				end
			end
			OP_REPLACE: begin
				if (!in_range) st_d = ST_RANGE;
			end
			OP_RETRIEVE: begin
				if (!in_range) st_d = ST_RANGE;
				else rd_use = 1'b1;
			end
			OP_REMOVE: begin
				if (fill_q == '0) begin
					st_d = ST_UNDERFLOW;
				end else if (!in_range) begin
					st_d = ST_RANGE;
				end else begin
					rd_use = 1'b1;
					fill_d = fill_q - FW'(1);
				end
			end
			OP_CLEAR: fill_d = '0;
			default: ;
		endcase
	end

	// read select: only cells the 5-bit position can reach ever match
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (pos_x == CW'(i)) rd_val = rd_val | cell_q[i];
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [CW-1:0]         idx;
		logic [ENTRY_BITS-1:0] left_d;
		logic [ENTRY_BITS-1:0] right_d;

		assign idx = CW'(g);

		always_comb begin
			ctl[g].load_new   = in_fire && (ins_ok || rep_ok) && (idx == pos_x);
			ctl[g].take_left  = in_fire && ins_ok && (idx > pos_x) && (idx <= fill_x);
			ctl[g].take_right = in_fire && rem_ok && (idx >= pos_x) &&
				((idx + CW'(1)) < fill_x);
		end

		if (g == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_q[g+1];
		end

		plt_cell #(
			.ENTRY_BITS(ENTRY_BITS)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl[g]),
			.left_d  (left_d),
			.right_d (right_d),
			.new_d   (new_val),
			.entry_q (cell_q[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (in_fire) begin
				fill_q    <= fill_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result payload, loaded on each input transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			status      <= st_d;
			value_out   <= rd_use ? 32'(rd_val[OB-1:0]) : 32'd0;
			entry_count <= 5'(fill_d);
			is_empty    <= (fill_d == '0);
			is_full     <= (fill_d == FW'(CAPACITY));
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CAPACITY))
		else $error("entry count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (op == OP_CLEAR) |=> (fill_q == '0) && is_empty)
		else $error("clear did not empty the list");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && ins_ok |=> (fill_q == $past(fill_q) + FW'(1)) && (status == ST_OK))
		else $error("insert did not grow the list");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid)
		else $error("transfer gave no result");

endmodule
